FILE: design/buh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded undo/redo history block.
// No dependencies; every other design file imports this package.
package buh_pkg;

  // configuration register
  localparam int          LIMIT_W     = 7;
  localparam logic [6:0]  LIMIT_RESET = 7'd64;

  // APB-style port: one 32-bit register, word index taken from paddr[2]
  localparam int          PADDR_W     = 3;
  localparam int          PDATA_W     = 32;
  localparam logic        REG_LIMIT   = 1'b0;

  // defaults for the top-level parameters
  localparam int          DEPTH_DEFAULT       = 64;
  localparam int          HANDLE_BITS_DEFAULT = 32;

  // operation codes
  localparam int          KIND_W    = 2;
  localparam logic [1:0]  KIND_PUSH = 2'd0;
  localparam logic [1:0]  KIND_UNDO = 2'd1;
  localparam logic [1:0]  KIND_REDO = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic push;
    logic undo;
    logic redo;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic can_undo;
    logic can_redo;
  } status_t;

endpackage

FILE: design/bounded_undo_redo_history_top.sv
`timescale 1ns / 1ps
// Bounded undo/redo history: top level joining config, controller, datapath.
// The result strobe (done) comes from a registered state bit and rises in the cycle after the beat is accepted.
// Throughput: one item per cycle; busy stays low, since each item makes a
// single access to the handle ring memory and a small counter update.
// Reset (rst, synchronous) empties the history and sets history_limit to 64;
// the receiver cannot stall, each result is shown for exactly one cycle.
module bounded_undo_redo_history_top #(
  parameter int DEPTH       = buh_pkg::DEPTH_DEFAULT,
  parameter int HANDLE_BITS = buh_pkg::HANDLE_BITS_DEFAULT,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [buh_pkg::KIND_W-1:0]   kind,
  input  logic [HANDLE_BITS-1:0]       handle,
  output logic                         done,
  output logic [HANDLE_BITS-1:0]       returned_handle,
  output logic                         handle_valid,
  output logic                         undo_possible,
  output logic                         redo_possible,
  output logic [CNT_W-1:0]             stored_entries,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [buh_pkg::PADDR_W-1:0]  paddr,
  input  logic [buh_pkg::PDATA_W-1:0]  pwdata,
  output logic [buh_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import buh_pkg::*;

  logic [LIMIT_W-1:0] history_limit;
  cmd_t               cmd;
  status_t            status;
  logic               hit;

  buh_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .history_limit (history_limit)
  );

  buh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .hit    (hit)
  );

  buh_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .hit             (hit),
    .handle          (handle),
    .history_limit   (history_limit),
    .status          (status),
    .returned_handle (returned_handle),
    .handle_valid    (handle_valid),
    .undo_possible   (undo_possible),
    .redo_possible   (redo_possible),
    .stored_entries  (stored_entries)
  );

  // every accepted beat produces exactly one result strobe
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done) else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done) else $error("result strobe without a beat");

  // a push always leaves nothing to redo
  a_push_no_redo: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_PUSH) |=> !redo_possible)
    else $error("redo branch survived a push");

  // counters stay within the ring
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (stored_entries <= CNT_W'(DEPTH)) && (!undo_possible || stored_entries != '0))
    else $error("entry count out of range");

endmodule

FILE: design/buh_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: history_limit behind an APB-style port.
// Depends on buh_pkg.
module buh_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [buh_pkg::PADDR_W-1:0]  paddr,
  input  logic [buh_pkg::PDATA_W-1:0]  pwdata,
  output logic [buh_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [buh_pkg::LIMIT_W-1:0]  history_limit
);
  import buh_pkg::*;

  logic wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel & penable & pwrite & pready;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      history_limit <= LIMIT_RESET;
    end else if (wr_beat && paddr[2] == REG_LIMIT) begin
      history_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(history_limit) : '0;

endmodule

FILE: design/buh_ctrl.sv
`timescale 1ns / 1ps
// Controller: accepts commands, decides the datapath operation and
// raises the result strobe in the next cycle. Depends on buh_pkg.
module buh_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [buh_pkg::KIND_W-1:0]  kind,
  input  buh_pkg::status_t            status,
  output logic                        busy,
  output buh_pkg::cmd_t               cmd,
  output logic                        done,
  output logic                        hit
);
  import buh_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RESULT = 1'b1;

  logic state;
  logic state_next;
  logic accept;
  logic hit_next;

  // memory port and counters are free every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // decode the beat into a datapath command
  always_comb begin
    cmd      = '0;
    hit_next = 1'b0;
    if (accept) begin
      unique case (kind)
        KIND_PUSH: cmd.push = 1'b1;
        KIND_UNDO: begin
          cmd.undo = status.can_undo;
          hit_next = status.can_undo;
        end
        KIND_REDO: begin
          cmd.redo = status.can_redo;
          hit_next = status.can_redo;
        end
        default: ;
      endcase
    end
  end

  assign state_next = accept ? ST_RESULT : ST_IDLE;

  // result strobe is registered and rises in the cycle after each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      hit   <= hit_next;
    end
  end

  assign done = (state == ST_RESULT);

endmodule

FILE: design/buh_dp.sv
`timescale 1ns / 1ps
// Datapath: handle ring memory, oldest pointer, entry and applied counters.
// Depends on buh_pkg.
module buh_dp #(
  parameter int DEPTH       = buh_pkg::DEPTH_DEFAULT,
  parameter int HANDLE_BITS = buh_pkg::HANDLE_BITS_DEFAULT,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  buh_pkg::cmd_t                cmd,
  input  logic                         hit,
  input  logic [HANDLE_BITS-1:0]       handle,
  input  logic [buh_pkg::LIMIT_W-1:0]  history_limit,
  output buh_pkg::status_t             status,
  output logic [HANDLE_BITS-1:0]       returned_handle,
  output logic                         handle_valid,
  output logic                         undo_possible,
  output logic                         redo_possible,
  output logic [CNT_W-1:0]             stored_entries
);
  import buh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = CNT_W + 2;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [HANDLE_BITS-1:0] ring [DEPTH];
  logic [HANDLE_BITS-1:0] rdata;
  logic [PTR_W-1:0]       oldest;
  logic [CNT_W-1:0]       entries;
  logic [CNT_W-1:0]       applied;

  logic [CNT_W-1:0]       ofs;
  logic [PTR_W-1:0]       slot;
  logic [CMP_W-1:0]       lim_wide;
  logic [CNT_W-1:0]       eff_lim;
  logic [CNT_W:0]         grown;
  logic [CNT_W:0]         excess;
  logic                   over;
  logic [PTR_W-1:0]       oldest_next;

  // one conditional subtract of DEPTH
  function automatic logic [SUM_W-1:0] sub_depth(input logic [SUM_W-1:0] s);
    sub_depth = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
  endfunction

  // ring slot of the entry touched by this beat
  always_comb begin
    ofs  = cmd.undo ? applied - CNT_W'(1) : applied;
    slot = PTR_W'(sub_depth(SUM_W'(oldest) + SUM_W'(ofs)));
  end

  // eviction after a push: clamp limit to DEPTH, drop the excess
  always_comb begin
    lim_wide    = (CMP_W'(history_limit) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(history_limit);
    eff_lim     = lim_wide[CNT_W-1:0];
    grown       = {1'b0, applied} + (CNT_W+1)'(1);
    over        = grown > {1'b0, eff_lim};
    excess      = grown - {1'b0, eff_lim};
    // oldest + excess can reach 2*DEPTH, so wrap twice
    oldest_next = PTR_W'(sub_depth(sub_depth(SUM_W'(oldest) + SUM_W'(excess))));
  end

  // pointer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest  <= '0;
      entries <= '0;
      applied <= '0;
    end else if (cmd.push) begin
      if (over) begin
        oldest  <= oldest_next;
        entries <= eff_lim;
        applied <= eff_lim;
      end else begin
        entries <= grown[CNT_W-1:0];
        applied <= grown[CNT_W-1:0];
      end
    end else if (cmd.undo) begin
      applied <= applied - CNT_W'(1);
    end else if (cmd.redo) begin
      applied <= applied + CNT_W'(1);
    end
  end

  // handle ring: one access per beat, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring[slot] <= handle;
    end
    if (cmd.undo | cmd.redo) begin
      rdata <= ring[slot];
    end
  end

  assign status.can_undo = (applied != '0);
  assign status.can_redo = (applied < entries);

  // result fields, valid while the strobe is up
  assign returned_handle = hit ? rdata : '0;
  assign handle_valid    = hit;
  assign undo_possible   = status.can_undo;
  assign redo_possible   = status.can_redo;
  assign stored_entries  = entries;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_undo_redo_history_top: a directed table, then random
// phases under several limits, checked against row results or a predictor kept here.
// Depends on buh_pkg and the top-level RTL only.
module testbench;
  import buh_pkg::*;

  localparam int HB       = HANDLE_BITS_DEFAULT;
  localparam int DEPTH    = DEPTH_DEFAULT;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int RESULT_LATENCY = 1;
  localparam logic [1:0] KIND_NONE = 2'd3;   // unused code, block ignores it
  localparam logic [PADDR_W-1:0] ADDR_LIMIT = {REG_LIMIT, 2'b00};
  localparam bit ROW_ITEM = 1'b0;
  localparam bit ROW_CFG  = 1'b1;
  localparam bit PRD = 1'b0;   // row checked against predictor
  localparam bit CHK = 1'b1;   // row carries its own expected result

  typedef struct packed {
    logic [HB-1:0]    handle;
    logic             valid;
    logic             undo_ok;
    logic             redo_ok;
    logic [CNT_W-1:0] entries;
  } history_result_t;

  typedef struct packed {
    logic            is_cfg;
    logic [1:0]      kind;
    logic [HB-1:0]   hnd;      // handle, or new limit on a config row
    logic            typed;
    history_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] kind = KIND_UNDO;
  logic [HB-1:0] handle = '0;
  logic done;
  logic [HB-1:0] returned_handle;
  logic handle_valid;
  logic undo_possible;
  logic redo_possible;
  logic [CNT_W-1:0] stored_entries;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bounded_undo_redo_history_top #(.DEPTH(DEPTH), .HANDLE_BITS(HB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .handle(handle),
    .done(done), .returned_handle(returned_handle), .handle_valid(handle_valid),
    .undo_possible(undo_possible), .redo_possible(redo_possible),
    .stored_entries(stored_entries), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // history model state
  logic [HB-1:0] ring_model [DEPTH];
  int unsigned   oldest_q;
  int unsigned   count_q;
  int unsigned   applied_q;
  int unsigned   limit_q;

  history_result_t expected_results [$];
  dir_row_t        dir_rows [$];
  int              mismatch_count = 0;

  // one history operation: updates the model and returns the result beat
  function automatic history_result_t predict_history_step(logic [1:0] k, logic [HB-1:0] h);
    history_result_t r;
    int unsigned lim;
    int unsigned excess;
    r = '0;
    if (k == KIND_PUSH) begin
      // redo branch dropped; with nothing applied the history starts over
      count_q = applied_q;
      ring_model[PTR_W'((oldest_q + count_q) % DEPTH)] = h;
      count_q++;
      applied_q = count_q;
      lim = (limit_q > DEPTH) ? DEPTH : limit_q;
      if (count_q > lim) begin
        excess    = count_q - lim;
        oldest_q  = (oldest_q + excess) % DEPTH;
        count_q   -= excess;
        applied_q -= excess;
      end
    end else if (k == KIND_UNDO) begin
      if (applied_q > 0) begin
        r.handle = ring_model[PTR_W'((oldest_q + applied_q - 1) % DEPTH)];
        r.valid  = 1'b1;
        applied_q--;
      end
    end else if (k == KIND_REDO) begin
      if (applied_q < count_q) begin
        r.handle = ring_model[PTR_W'((oldest_q + applied_q) % DEPTH)];
        r.valid  = 1'b1;
        applied_q++;
      end
    end
    r.undo_ok = (applied_q > 0);
    r.redo_ok = (applied_q < count_q);
    r.entries = count_q[CNT_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t mk_row(bit is_cfg, logic [1:0] k, logic [HB-1:0] h, bit typed,
                                      logic [HB-1:0] rh, bit v, bit u, bit rd, int n);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.kind   = k;
    row.hnd    = h;
    row.typed  = typed;
    row.res    = '{handle: rh, valid: v, undo_ok: u, redo_ok: rd, entries: n[CNT_W-1:0]};
    return row;
  endfunction

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // result checker: each strobe is compared with the oldest expectation
  always @(posedge clk) begin
    history_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no pending expectation, handle %0h",
                 $time, returned_handle);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        report_field("returned_handle", 64'(exp_r.handle), 64'(returned_handle));
        report_field("handle_valid", 64'(exp_r.valid), 64'(handle_valid));
        report_field("undo_possible", 64'(exp_r.undo_ok), 64'(undo_possible));
        report_field("redo_possible", 64'(exp_r.redo_ok), 64'(redo_possible));
        report_field("stored_entries", 64'(exp_r.entries), 64'(stored_entries));
      end
    end
  end

  // drive one beat and log its expectation at the accepting edge
  task automatic send_item(logic [1:0] k, logic [HB-1:0] h, bit typed, history_result_t typed_r);
    history_result_t r;
    @(negedge clk);
    start  = 1'b1;
    kind   = k;
    handle = h;
    do @(posedge clk); while (busy);
    r = predict_history_step(k, h);
    expected_results.push_back(typed ? typed_r : r);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off until every pending result has come back
  task automatic wait_quiet();
    if (start) begin
      @(negedge clk);
      start = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // write the limit register, then read it back
  task automatic write_limit(logic [6:0] lim);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_LIMIT;
    pwdata  = {{(PDATA_W - 7){1'b0}}, lim};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    limit_q = 32'(lim);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    report_field("prdata", 64'({{(PDATA_W - 7){1'b0}}, lim}), 64'(prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // random phase: new limit, then n beats with a given share of pushes
  task automatic run_phase(logic [6:0] lim, int n, int push_pct);
    logic [1:0]    k;
    logic [HB-1:0] h;
    int            r;
    wait_quiet();
    write_limit(lim);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) k = KIND_PUSH;
      else if (r < 96) k = ($urandom_range(0, 1) != 0) ? KIND_UNDO : KIND_REDO;
      else k = KIND_NONE;
      case ($urandom_range(0, 15))
        0: h = '0;
        1: h = '1;
        default: h = $urandom;
      endcase
      send_item(k, h, PRD, '0);
      if ($urandom_range(0, 29) == 0) wait_quiet();
      else idle_gap($urandom_range(0, 9));
    end
  endtask

  // run timeout
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t row;
    oldest_q  = 0;
    count_q   = 0;
    applied_q = 0;
    limit_q   = 32'(LIMIT_RESET);
    foreach (ring_model[i]) ring_model[i] = '0;

    // directed table: empty history, extremes of handles, special cases
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0,        CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_REDO, 32'h0,        CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'hFFFFFFFF, CHK, 32'h0, 0, 1, 0, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0, CHK, 32'hFFFFFFFF, 1, 0, 1, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_REDO, 32'h0, CHK, 32'hFFFFFFFF, 1, 1, 0, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h0,        CHK, 32'h0, 0, 1, 0, 2));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_NONE, 32'hAAAAAAAA, CHK, 32'h0, 0, 1, 0, 2));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h55555555, CHK, 32'h0, 0, 1, 0, 3));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0, CHK, 32'h55555555, 1, 1, 1, 3));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0,        CHK, 32'h0, 1, 1, 1, 3));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0, CHK, 32'hFFFFFFFF, 1, 0, 1, 3));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0,        CHK, 32'h0, 0, 0, 1, 3));
    // push with everything undone starts the history over
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h12345678, CHK, 32'h0, 0, 1, 0, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_REDO, 32'h0,        CHK, 32'h0, 0, 1, 0, 1));
    // limit of one: each push evicts the previous entry
    dir_rows.push_back(mk_row(ROW_CFG,  KIND_PUSH, 32'd1,        CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'hA5A5A5A5, CHK, 32'h0, 0, 1, 0, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0, CHK, 32'hA5A5A5A5, 1, 0, 1, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_REDO, 32'h0, CHK, 32'hA5A5A5A5, 1, 1, 0, 1));
    // limit of zero: a push leaves the history empty
    dir_rows.push_back(mk_row(ROW_CFG,  KIND_PUSH, 32'd0,        CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h5A5A5A5A, CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0,        CHK, 32'h0, 0, 0, 0, 0));
    // limit above the ring size, then lowered while entries are held
    dir_rows.push_back(mk_row(ROW_CFG,  KIND_PUSH, 32'd127,      CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h1,        CHK, 32'h0, 0, 1, 0, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h2,        PRD, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h3,        PRD, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h4,        PRD, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG,  KIND_PUSH, 32'd2,        CHK, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_UNDO, 32'h0,        PRD, 32'h0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, KIND_PUSH, 32'h80000000, PRD, 32'h0, 0, 0, 0, 0));

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_quiet();
        write_limit(row.hnd[6:0]);
      end else begin
        send_item(row.kind, row.hnd, row.typed, row.res);
        idle_gap($urandom_range(0, 9));
      end
    end

    // random phases across limits, extremes included
    run_phase(7'd64,  120, 75);
    run_phase(7'd127, 80,  60);
    run_phase(7'd1,   30,  50);
    run_phase(7'd0,   20,  50);
    run_phase(7'd65,  60,  65);
    run_phase(7'($urandom_range(2, 8)), 60, 55);
    run_phase(7'($urandom_range(1, 127)), 50, 60);
    run_phase(7'd63,  40,  60);

    // drain and report
    wait_quiet();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
